[sv/mxt_pkg.sv]
`timescale 1ns / 1ps

package mxt_pkg;

  localparam int KEY_BITS   = 32;
  localparam int NODE_COUNT = 32768;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int NF_W       = NODE_W + 1;
  localparam int CNT_W      = 16;
  localparam int LVL_W      = $clog2(KEY_BITS);
  localparam int KEY_W      = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FRESH,
    S_DONE
  } state_t;

  // children of one node and the pass counts of those children
  typedef struct packed {
    logic [NODE_W-1:0] zc;
    logic [NODE_W-1:0] oc;
    logic [CNT_W-1:0]  zn;
    logic [CNT_W-1:0]  on;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  function automatic logic [NODE_W-1:0] ent_ptr(ent_t e, logic b);
    ent_ptr = b ? e.oc : e.zc;
  endfunction

  function automatic logic [CNT_W-1:0] ent_cnt(ent_t e, logic b);
    ent_cnt = b ? e.on : e.zn;
  endfunction

  function automatic ent_t ent_set(ent_t e, logic b, logic [NODE_W-1:0] p,
                                   logic [CNT_W-1:0] c);
    ent_t r;
    r = e;
    if (b) begin
      r.oc = p;
      r.on = c;
    end else begin
      r.zc = p;
      r.zn = c;
    end
    ent_set = r;
  endfunction

endpackage

[sv/mxt_ram.sv]
`timescale 1ns / 1ps

module mxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/max_xor_partner_trie_top.sv]
`timescale 1ns / 1ps
// A query, or an insert with at least 32 free nodes, walks one trie level per cycle and then
// registers its result word; a new word is accepted only once that result word is loaded.
// Remove and an insert with fewer than 32 free nodes run a read-only check walk first and
// then the update walk. Empty store, absent value, full pool and an unused opcode end early;
// a stalled result word holds the input until it is taken.
// Reset empties the store: root entry and counts clear, node pointer returns to one.

module max_xor_partner_trie_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_opcode,
  input  logic [mxt_pkg::KEY_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mxt_pkg::KEY_W-1:0] out_partner,
  output logic [1:0]                out_status
);

  import mxt_pkg::*;

  state_t             state_r, state_nxt;
  op_t                op_r;
  logic [KEY_W-1:0]   key_r;
  logic [LVL_W-1:0]   level_r;
  logic [NODE_W-1:0]  node_r;
  logic [KEY_W-1:0]   acc_r;
  logic               upd_r;
  logic [NF_W-1:0]    nf_r;
  ent_t               root_r;
  logic [CNT_W-1:0]   root_cnt_r;
  logic [KEY_W-1:0]   res_partner_r;
  st_t                res_status_r;
  logic               out_valid_r;
  logic [KEY_W-1:0]   out_partner_r;
  st_t                out_status_r;

  ent_t               rd_ent;
  logic [ENT_W-1:0]   rd_data;
  ent_t               cur_ent;
  logic               top;
  logic               last;
  logic               kb;
  logic               q_want;
  logic               q_take;
  logic               mb;
  logic [NODE_W-1:0]  child;
  logic [CNT_W-1:0]   ccnt;
  logic               live_m;
  logic [NF_W-1:0]    free_c;
  logic [NF_W-1:0]    need_c;
  logic               accept;
  logic               out_free;

  logic               fin;
  st_t                fin_st;
  logic [KEY_W-1:0]   fin_par;
  logic               go_next;
  logic               go_upd;
  logic               go_fresh;
  logic               alloc;
  logic               wr_en;
  ent_t               new_ent;
  logic [KEY_W-1:0]   acc_q;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign rd_ent   = ent_t'(rd_data);
  assign top      = (level_r == LVL_W'(KEY_BITS - 1));
  assign last     = (level_r == '0);
  assign cur_ent  = top ? root_r : rd_ent;
  assign kb       = key_r[level_r];
  assign q_want   = ~kb;
  assign q_take   = (ent_ptr(cur_ent, q_want) != '0 && ent_cnt(cur_ent, q_want) != '0)
                    ? q_want : kb;
  assign mb       = (op_r == OP_QUERY) ? q_take : kb;
  assign child    = ent_ptr(cur_ent, mb);
  assign ccnt     = ent_cnt(cur_ent, mb);
  assign live_m   = (child != '0) && (ccnt != '0);
  assign free_c   = NF_W'(NODE_COUNT) - nf_r;
  assign need_c   = NF_W'(level_r) + NF_W'(1);

  mxt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (wr_en && !top),
    .waddr (node_r),
    .wdata (new_ent),
    .raddr (child),
    .rdata (rd_data)
  );

  always_comb begin
    fin      = 1'b0;
    fin_st   = ST_OK;
    fin_par  = '0;
    go_next  = 1'b0;
    go_upd   = 1'b0;
    go_fresh = 1'b0;
    alloc    = 1'b0;
    wr_en    = 1'b0;
    new_ent  = cur_ent;
    acc_q    = acc_r;
    acc_q[level_r] = q_take;
    unique case (state_r)
      S_WALK: begin
        if (top && op_r == OP_QUERY && root_cnt_r == '0) begin
          fin    = 1'b1;
          fin_st = ST_EMPTY;
        end else if (top && op_r == OP_REMOVE && root_cnt_r == '0) begin
          fin    = 1'b1;
          fin_st = ST_ABSENT;
        end else if (top && op_r == OP_INSERT && root_cnt_r == CNT_MAX) begin
          fin    = 1'b1;
          fin_st = ST_FULL;
        end else begin
          case (op_r)
            OP_QUERY: begin
              if (!live_m) begin
                fin     = 1'b1;
                fin_par = acc_r;
              end else if (last) begin
                fin     = 1'b1;
                fin_par = acc_q;
              end else begin
                go_next = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (!upd_r) begin
                if (!live_m) begin
                  fin    = 1'b1;
                  fin_st = ST_ABSENT;
                end else if (last) begin
                  go_upd = 1'b1;
                end else begin
                  go_next = 1'b1;
                end
              end else begin
                wr_en   = 1'b1;
                new_ent = ent_set(cur_ent, kb, child, ccnt - CNT_W'(1));
                if (last) begin
                  fin = 1'b1;
                end else begin
                  go_next = 1'b1;
                end
              end
            end
            OP_INSERT: begin
              if (!upd_r) begin
                if (child == '0) begin
                  if (need_c > free_c) begin
                    fin    = 1'b1;
                    fin_st = ST_FULL;
                  end else begin
                    go_upd = 1'b1;
                  end
                end else if (last) begin
                  go_upd = 1'b1;
                end else begin
                  go_next = 1'b1;
                end
              end else begin
                wr_en = 1'b1;
                if (child != '0) begin
                  new_ent = ent_set(cur_ent, kb, child, ccnt + CNT_W'(1));
                  if (last) begin
                    fin = 1'b1;
                  end else begin
                    go_next = 1'b1;
                  end
                end else begin
                  alloc   = 1'b1;
                  new_ent = ent_set(cur_ent, kb, nf_r[NODE_W-1:0], CNT_W'(1));
                  if (last) begin
                    fin = 1'b1;
                  end else begin
                    go_fresh = 1'b1;
                  end
                end
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_FRESH: begin
        wr_en   = 1'b1;
        alloc   = 1'b1;
        new_ent = ent_set('0, kb, nf_r[NODE_W-1:0], CNT_W'(1));
        if (last) begin
          fin = 1'b1;
        end else begin
          go_fresh = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (op_t'(in_opcode) == OP_NONE) ? S_DONE : S_WALK;
        end
      end
      S_WALK: begin
        if (fin) begin
          state_nxt = S_DONE;
        end else if (go_fresh) begin
          state_nxt = S_FRESH;
        end
      end
      S_FRESH: begin
        if (fin) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == S_IDLE);
    out_valid   = out_valid_r;
    out_partner = out_partner_r;
    out_status  = out_status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      upd_r       <= 1'b0;
      nf_r        <= NF_W'(1);
      root_r      <= '0;
      root_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        upd_r <= (op_t'(in_opcode) == OP_INSERT) && (free_c >= NF_W'(KEY_BITS));
      end else if (go_upd) begin
        upd_r <= 1'b1;
      end
      if (alloc) begin
        nf_r <= nf_r + NF_W'(1);
      end
      if (wr_en && top) begin
        root_r     <= new_ent;
        root_cnt_r <= (op_r == OP_INSERT) ? root_cnt_r + CNT_W'(1)
                                          : root_cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r          <= op_t'(in_opcode);
      key_r         <= in_value;
      level_r       <= LVL_W'(KEY_BITS - 1);
      node_r        <= '0;
      acc_r         <= '0;
      res_partner_r <= '0;
      res_status_r  <= ST_OK;
    end else if (go_upd) begin
      level_r <= LVL_W'(KEY_BITS - 1);
      node_r  <= '0;
    end else if (go_next) begin
      level_r <= level_r - LVL_W'(1);
      node_r  <= child;
      acc_r   <= acc_q;
    end else if (go_fresh) begin
      level_r <= level_r - LVL_W'(1);
      node_r  <= nf_r[NODE_W-1:0];
    end
    if (fin) begin
      res_partner_r <= fin_par;
      res_status_r  <= fin_st;
    end
    if (state_r == S_DONE && out_free) begin
      out_partner_r <= res_partner_r;
      out_status_r  <= res_status_r;
    end
  end

endmodule
